[sv/dtas_pkg.sv]
// Shared constants, types and helper functions for the date-time add-seconds block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dtas_pkg;

    // Bias in whole days that keeps the offset sum nonnegative
    localparam logic [19:0] BIAS_DAYS     = 20'd99421;
    localparam logic [35:0] BIAS_SECONDS  = 36'd8589974400;   // BIAS_DAYS * 86400
    localparam logic [23:0] DAYS_PER_ERA  = 24'd146097;
    localparam logic [18:0] RECIP_675     = 19'd397682;        // floor(2^28 / 675)
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam int          TOD_DELAY     = 5;

    typedef struct packed {
        logic [15:0] year;    // two's complement, may fall outside 1..9999
        logic [3:0]  month;
        logic [4:0]  day;
        logic        under;   // year below 1
        logic        over;    // year above 9999
    } date_t;

    // Days from March 1 to the first of the month, March-based month index
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Exact floor(v / 100) for v below 400
    function automatic logic [1:0] div100(input logic [8:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd41;
        return p[13:12];
    endfunction

endpackage

[sv/datetime_add_seconds.sv]
// Top level of the date-time add-seconds block: stream ports, pipeline control, clamping.
// Depends on dtas_pkg, dtas_front, dtas_civil and dtas_tod.
`timescale 1ns / 1ps

// Adds a signed offset in seconds to a Gregorian date-time and returns the shifted
// date-time, clamped to 0001-01-01 00:00:00 or 9999-12-31 23:59:59 with out_of_range
// set when the result year leaves 1..9999. The block is a 15-stage pipeline that
// accepts one request every cycle while the output is not stalled; the depth is
// set by the chain of reciprocal-multiply divisions that turns a day number back
// into a calendar date. A stalled result holds the whole pipeline, so s_tready
// falls while m_tvalid is high and m_tready is low.
module datetime_add_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // base_year[13:0], base_month[17:14], base_day[22:18], base_hour[27:23],
    // base_minute[33:28], base_second[39:34], offset_seconds[73:40], zeros[79:74]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23],
    // new_minute[33:28], new_second[39:34], out_of_range[40], zeros[47:41]
    output logic [47:0] m_tdata
);
    import dtas_pkg::*;

    logic        adv;
    logic        front_vld, civil_vld;
    logic [22:0] day_num;
    logic [16:0] sod;
    date_t       date;
    logic [4:0]  hour;
    logic [5:0]  minute, second;

    logic        vld_reg;
    logic [47:0] data_reg, data_next;

    assign adv      = !vld_reg || m_tready;
    assign s_tready = adv;

    dtas_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .year    (s_tdata[13:0]),
        .month   (s_tdata[17:14]),
        .day     (s_tdata[22:18]),
        .hour    (s_tdata[27:23]),
        .minute  (s_tdata[33:28]),
        .second  (s_tdata[39:34]),
        .offset  (s_tdata[73:40]),
        .out_vld (front_vld),
        .day_num (day_num),
        .sod     (sod)
    );

    dtas_civil u_civil (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (front_vld),
        .day_num (day_num),
        .out_vld (civil_vld),
        .date    (date)
    );

    dtas_tod u_tod (
        .clk    (clk),
        .adv    (adv),
        .sod    (sod),
        .hour   (hour),
        .minute (minute),
        .second (second)
    );

    always_comb
    begin
        priority if (date.under)
        begin
            data_next = {7'd0, 1'b1, 6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 14'd1};
        end
        else if (date.over)
        begin
            data_next = {7'd0, 1'b1, 6'd59, 6'd59, 5'd23, 5'd31, 4'd12, YEAR_MAX};
        end
        else
        begin
            data_next = {7'd0, 1'b0, second, minute, hour, date.day, date.month,
                         date.year[13:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= civil_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;

    a_clamp_year: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> (m_tdata[13:0] == 14'd1 || m_tdata[13:0] == YEAR_MAX))
        else $error("clamped result with a year other than 1 or 9999");

    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12))
        else $error("result month out of range");

    a_day: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:18] >= 5'd1))
        else $error("result day is zero");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[27:23] <= 5'd23 && m_tdata[33:28] <= 6'd59
                      && m_tdata[39:34] <= 6'd59))
        else $error("result time of day out of range");

endmodule

[sv/dtas_front.sv]
// Front pipeline: base date to biased day number, offset split into days and seconds.
// Depends on dtas_pkg; five register stages advanced by adv.
`timescale 1ns / 1ps

module dtas_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [33:0] offset,
    output logic        out_vld,
    output logic [22:0] day_num,
    output logic [16:0] sod
);
    import dtas_pkg::*;

    logic [4:0]  vld_reg, vld_next;

    // stage 1
    logic [14:0] f1_yp_reg, f1_yp_next;
    logic [3:0]  f1_mc_reg, f1_mc_next;
    logic [4:0]  f1_day_reg;
    logic [34:0] f1_t_reg, f1_t_next;
    logic [16:0] tod0;
    logic [35:0] tsum;
    // stage 2
    logic [14:0] f2_yp_reg;
    logic [3:0]  f2_mc_reg;
    logic [4:0]  f2_day_reg;
    logic [27:0] f2_th_reg;
    logic [6:0]  f2_tl_reg;
    logic [5:0]  f2_era_reg, f2_era_next;
    logic [18:0] f2_qd_reg, f2_qd_next;
    logic [21:0] era_prod;
    logic [46:0] qd_prod;
    // stage 3
    logic [5:0]  f3_era_reg, f3_era_next;
    logic [8:0]  f3_yoe_reg, f3_yoe_next;
    logic [18:0] f3_qd_reg, f3_qd_next;
    logic [16:0] f3_sod_reg, f3_sod_next;
    logic [3:0]  f3_mc_reg;
    logic [4:0]  f3_day_reg;
    logic [15:0] r1, r1c;
    logic [27:0] rd;
    logic [10:0] rdc;
    // stage 4
    logic [22:0] f4_zp_reg, f4_zp_next;
    logic [19:0] f4_dd_reg, f4_dd_next;
    logic [16:0] f4_sod_reg;
    logic [3:0]  mp1;
    logic [17:0] doe1;
    // stage 5
    logic [22:0] f5_z_reg, f5_z_next;
    logic [16:0] f5_sod_reg;

    assign vld_next = {vld_reg[3:0], in_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        if (month == 4'd0)
        begin
            f1_mc_next = 4'd1;
        end
        else if (month > 4'd12)
        begin
            f1_mc_next = 4'd12;
        end
        else
        begin
            f1_mc_next = month;
        end
        // January and February belong to the previous March-based year
        f1_yp_next = 15'(year) + 15'd400 - 15'(f1_mc_next <= 4'd2);
        tod0 = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
        tsum = {{2{offset[33]}}, offset} + 36'(tod0) + BIAS_SECONDS;
        f1_t_next = tsum[34:0];
    end

    always_comb
    begin
        era_prod = 22'(f1_yp_reg) * 22'd81;
        f2_era_next = era_prod[20:15];
        qd_prod = 47'(f1_t_reg[34:7]) * 47'(RECIP_675);
        f2_qd_next = qd_prod[46:28];
    end

    always_comb
    begin
        r1 = 16'(f2_yp_reg) - 16'(f2_era_reg) * 16'd400;
        if (r1 >= 16'd400)
        begin
            f3_era_next = f2_era_reg + 6'd1;
            r1c = r1 - 16'd400;
        end
        else
        begin
            f3_era_next = f2_era_reg;
            r1c = r1;
        end
        f3_yoe_next = r1c[8:0];
        rd = f2_th_reg - 28'(f2_qd_reg) * 28'd675;
        if (rd[10:0] >= 11'd675)
        begin
            f3_qd_next = f2_qd_reg + 19'd1;
            rdc = rd[10:0] - 11'd675;
        end
        else
        begin
            f3_qd_next = f2_qd_reg;
            rdc = rd[10:0];
        end
        f3_sod_next = {rdc[9:0], f2_tl_reg};
    end

    always_comb
    begin
        mp1 = (f3_mc_reg >= 4'd3) ? f3_mc_reg - 4'd3 : f3_mc_reg + 4'd9;
        doe1 = 18'(f3_yoe_reg) * 18'd365 + 18'(f3_yoe_reg[8:2])
             - 18'(div100(f3_yoe_reg)) + 18'(month_start(mp1));
        f4_zp_next = 23'(f3_era_reg) * 23'(DAYS_PER_ERA) + 23'(doe1);
        f4_dd_next = 20'(f3_day_reg) - 20'd1 + 20'(f3_qd_reg) - BIAS_DAYS;
        f5_z_next = f4_zp_reg + {{3{f4_dd_reg[19]}}, f4_dd_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_yp_reg  <= f1_yp_next;
            f1_mc_reg  <= f1_mc_next;
            f1_day_reg <= day;
            f1_t_reg   <= f1_t_next;
            f2_yp_reg  <= f1_yp_reg;
            f2_mc_reg  <= f1_mc_reg;
            f2_day_reg <= f1_day_reg;
            f2_th_reg  <= f1_t_reg[34:7];
            f2_tl_reg  <= f1_t_reg[6:0];
            f2_era_reg <= f2_era_next;
            f2_qd_reg  <= f2_qd_next;
            f3_era_reg <= f3_era_next;
            f3_yoe_reg <= f3_yoe_next;
            f3_qd_reg  <= f3_qd_next;
            f3_sod_reg <= f3_sod_next;
            f3_mc_reg  <= f2_mc_reg;
            f3_day_reg <= f2_day_reg;
            f4_zp_reg  <= f4_zp_next;
            f4_dd_reg  <= f4_dd_next;
            f4_sod_reg <= f3_sod_reg;
            f5_z_reg   <= f5_z_next;
            f5_sod_reg <= f4_sod_reg;
        end
    end

    assign out_vld = vld_reg[4];
    assign day_num = f5_z_reg;
    assign sod     = f5_sod_reg;

endmodule

[sv/dtas_civil.sv]
// Civil-date pipeline: biased day number back to year, month and day.
// Depends on dtas_pkg; nine register stages advanced by adv.
`timescale 1ns / 1ps

module dtas_civil (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  logic [22:0]    day_num,
    output logic           out_vld,
    output dtas_pkg::date_t date
);
    import dtas_pkg::*;

    logic [8:0]  vld_reg, vld_next;

    logic [22:0] c1_z_reg;
    logic [5:0]  c1_era_reg, c1_era_next;
    logic [28:0] era_prod;

    logic [5:0]  c2_era_reg, c2_era_next;
    logic [17:0] c2_doe_reg, c2_doe_next;
    logic [23:0] rz;

    logic [5:0]  c3_era_reg;
    logic [17:0] c3_doe_reg;
    logic [7:0]  c3_e1_reg, c3_e1_next;
    logic [2:0]  c3_e2_reg, c3_e2_next;
    logic [25:0] p1;
    logic [20:0] p2;

    logic [5:0]  c4_era_reg;
    logic [17:0] c4_doe_reg;
    logic [17:0] c4_a_reg, c4_a_next;
    logic [17:0] rem1, rem2;
    logic [7:0]  q1;
    logic [2:0]  q2;

    logic [5:0]  c5_era_reg;
    logic [17:0] c5_doe_reg;
    logic [17:0] c5_a_reg;
    logic [8:0]  c5_ye_reg, c5_ye_next;
    logic [27:0] ye_prod;

    logic [5:0]  c6_era_reg;
    logic [17:0] c6_doe_reg;
    logic [8:0]  c6_yoe_reg, c6_yoe_next;
    logic [17:0] ry;

    logic [5:0]  c7_era_reg;
    logic [8:0]  c7_yoe_reg;
    logic [8:0]  c7_doy_reg, c7_doy_next;
    logic [17:0] doy_w;

    logic [5:0]  c8_era_reg;
    logic [8:0]  c8_yoe_reg;
    logic [8:0]  c8_doy_reg;
    logic [10:0] c8_v_reg, c8_v_next;
    logic [3:0]  c8_mpe_reg, c8_mpe_next;
    logic [14:0] mp_prod;

    date_t       c9_date_reg, c9_date_next;
    logic [10:0] rv;
    logic [3:0]  mp, mon;
    logic [8:0]  day_w;
    logic [15:0] yr;

    assign vld_next = {vld_reg[7:0], in_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        era_prod = 29'(day_num) * 29'd57;
        c1_era_next = era_prod[28:23];

        rz = 24'(c1_z_reg) - 24'(c1_era_reg) * DAYS_PER_ERA;
        if (rz >= DAYS_PER_ERA)
        begin
            c2_era_next = c1_era_reg + 6'd1;
            c2_doe_next = 18'(rz - DAYS_PER_ERA);
        end
        else
        begin
            c2_era_next = c1_era_reg;
            c2_doe_next = rz[17:0];
        end

        p1 = 26'(c2_doe_reg) * 26'd179;
        c3_e1_next = p1[25:18];
        p2 = 21'(c2_doe_reg) * 21'd7;
        c3_e2_next = p2[20:18];

        // drop leap days: every 4 years, restore every 100, drop the era's last day
        rem1 = c3_doe_reg - 18'(c3_e1_reg) * 18'd1460;
        q1 = c3_e1_reg + 8'(rem1 >= 18'd1460);
        rem2 = c3_doe_reg - 18'(c3_e2_reg) * 18'd36524;
        q2 = c3_e2_reg + 3'(rem2 >= 18'd36524);
        c4_a_next = c3_doe_reg - 18'(q1) + 18'(q2) - 18'(c3_doe_reg == 18'd146096);

        ye_prod = 28'(c4_a_reg) * 28'd718;
        c5_ye_next = ye_prod[26:18];

        ry = c5_a_reg - 18'(c5_ye_reg) * 18'd365;
        c6_yoe_next = c5_ye_reg + 9'(ry >= 18'd365);

        doy_w = c6_doe_reg - (18'(c6_yoe_reg) * 18'd365 + 18'(c6_yoe_reg[8:2])
              - 18'(div100(c6_yoe_reg)));
        c7_doy_next = doy_w[8:0];

        c8_v_next = 11'(c7_doy_reg) * 11'd5 + 11'd2;
        mp_prod = 15'(c8_v_next) * 15'd13;
        c8_mpe_next = mp_prod[14:11];

        rv = c8_v_reg - 11'(c8_mpe_reg) * 11'd153;
        mp = c8_mpe_reg + 4'(rv >= 11'd153);
        day_w = c8_doy_reg - month_start(mp) + 9'd1;
        mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        // undo the one-era bias of the day number
        yr = 16'(c8_yoe_reg) + 16'(c8_era_reg) * 16'd400 + 16'(mon <= 4'd2) - 16'd400;
        c9_date_next.year  = yr;
        c9_date_next.month = mon;
        c9_date_next.day   = day_w[4:0];
        c9_date_next.under = ($signed(yr) < 16'sd1);
        c9_date_next.over  = ($signed(yr) > $signed({2'b00, YEAR_MAX}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_z_reg    <= day_num;
            c1_era_reg  <= c1_era_next;
            c2_era_reg  <= c2_era_next;
            c2_doe_reg  <= c2_doe_next;
            c3_era_reg  <= c2_era_reg;
            c3_doe_reg  <= c2_doe_reg;
            c3_e1_reg   <= c3_e1_next;
            c3_e2_reg   <= c3_e2_next;
            c4_era_reg  <= c3_era_reg;
            c4_doe_reg  <= c3_doe_reg;
            c4_a_reg    <= c4_a_next;
            c5_era_reg  <= c4_era_reg;
            c5_doe_reg  <= c4_doe_reg;
            c5_a_reg    <= c4_a_reg;
            c5_ye_reg   <= c5_ye_next;
            c6_era_reg  <= c5_era_reg;
            c6_doe_reg  <= c5_doe_reg;
            c6_yoe_reg  <= c6_yoe_next;
            c7_era_reg  <= c6_era_reg;
            c7_yoe_reg  <= c6_yoe_reg;
            c7_doy_reg  <= c7_doy_next;
            c8_era_reg  <= c7_era_reg;
            c8_yoe_reg  <= c7_yoe_reg;
            c8_doy_reg  <= c7_doy_reg;
            c8_v_reg    <= c8_v_next;
            c8_mpe_reg  <= c8_mpe_next;
            c9_date_reg <= c9_date_next;
        end
    end

    assign out_vld = vld_reg[8];
    assign date    = c9_date_reg;

endmodule

[sv/dtas_tod.sv]
// Time-of-day pipeline: seconds of day to hour, minute and second.
// Depends on dtas_pkg; nine stages in step with the civil-date pipeline.
`timescale 1ns / 1ps

module dtas_tod (
    input  logic        clk,
    input  logic        adv,
    input  logic [16:0] sod,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import dtas_pkg::*;

    logic [16:0] t1_sod_reg;
    logic [4:0]  t1_he_reg, t1_he_next;
    logic [22:0] h_prod;
    logic [4:0]  t2_h_reg, t2_h_next;
    logic [11:0] t2_rem_reg, t2_rem_next;
    logic [16:0] rh;
    logic [4:0]  t3_h_reg;
    logic [11:0] t3_rem_reg;
    logic [5:0]  t3_me_reg, t3_me_next;
    logic [18:0] m_prod;
    logic [5:0]  t4_m_next, t4_s_next;
    logic [11:0] rm;
    logic [4:0]  h_dly_reg [TOD_DELAY+1];
    logic [5:0]  m_dly_reg [TOD_DELAY+1];
    logic [5:0]  s_dly_reg [TOD_DELAY+1];

    always_comb
    begin
        h_prod = 23'(sod) * 23'd36;
        t1_he_next = h_prod[21:17];
        rh = t1_sod_reg - 17'(t1_he_reg) * 17'd3600;
        if (rh >= 17'd3600)
        begin
            t2_h_next = t1_he_reg + 5'd1;
            t2_rem_next = 12'(rh - 17'd3600);
        end
        else
        begin
            t2_h_next = t1_he_reg;
            t2_rem_next = rh[11:0];
        end
        m_prod = 19'(t2_rem_reg) * 19'd68;
        t3_me_next = m_prod[17:12];
        rm = t3_rem_reg - 12'(t3_me_reg) * 12'd60;
        if (rm >= 12'd60)
        begin
            t4_m_next = t3_me_reg + 6'd1;
            t4_s_next = 6'(rm - 12'd60);
        end
        else
        begin
            t4_m_next = t3_me_reg;
            t4_s_next = rm[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_sod_reg   <= sod;
            t1_he_reg    <= t1_he_next;
            t2_h_reg     <= t2_h_next;
            t2_rem_reg   <= t2_rem_next;
            t3_h_reg     <= t2_h_reg;
            t3_rem_reg   <= t2_rem_reg;
            t3_me_reg    <= t3_me_next;
            h_dly_reg[0] <= t3_h_reg;
            m_dly_reg[0] <= t4_m_next;
            s_dly_reg[0] <= t4_s_next;
            // hold alignment with the civil-date stages
            for (int i = 1; i <= TOD_DELAY; i++)
            begin
                h_dly_reg[i] <= h_dly_reg[i-1];
                m_dly_reg[i] <= m_dly_reg[i-1];
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    assign hour   = h_dly_reg[TOD_DELAY];
    assign minute = m_dly_reg[TOD_DELAY];
    assign second = s_dly_reg[TOD_DELAY];

endmodule

[sim/datetime_add_seconds_checker.sv]
// Checker for the date-time add-seconds block: watches both stream channels,
// predicts each result from the accepted request and compares field by field.
`timescale 1ns / 1ps

module datetime_add_seconds_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        out_of_range;
    } stamp_t;

    stamp_t expected_stamps[$];

    function automatic longint fdiv(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    // Day count of the first of a month, March-based eras
    function automatic longint first_of_month(input longint yr, input longint mo);
        longint y, era, yoe, doy;
        y = yr - (mo <= 2 ? 1 : 0);
        era = fdiv(y, 400);
        yoe = y - era * 400;
        doy = (153 * ((mo + 9) % 12) + 2) / 5;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function automatic stamp_t shifted_stamp(input logic [79:0] req);
        longint yr, mo, total, dn, tod, z, era, doe, yoe, doy, mp, m, d, y;
        stamp_t r;
        yr = req[13:0];
        mo = req[17:14];
        if (mo < 1)
            mo = 1;
        if (mo > 12)
            mo = 12;
        total = (first_of_month(yr, mo) + longint'(req[22:18]) - 1) * 86400
              + longint'(req[27:23]) * 3600 + longint'(req[33:28]) * 60
              + longint'(req[39:34]) + longint'($signed(req[73:40]));
        dn = fdiv(total, 86400);
        tod = total - dn * 86400;
        z = dn + 719468;
        era = fdiv(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        m = mp < 10 ? mp + 3 : mp - 9;
        d = doy - (153 * mp + 2) / 5 + 1;
        y = yoe + era * 400 + (m <= 2 ? 1 : 0);
        r.out_of_range = 1'b0;
        if (y < 1) begin
            y = 1; m = 1; d = 1; tod = 0; r.out_of_range = 1'b1;
        end else if (y > 9999) begin
            y = 9999; m = 12; d = 31; tod = 86399; r.out_of_range = 1'b1;
        end
        r.year = y[13:0];
        r.month = m[3:0];
        r.day = d[4:0];
        r.hour = 5'(tod / 3600);
        r.minute = 6'((tod % 3600) / 60);
        r.second = 6'(tod % 60);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = expected_stamps.size();

    always @(posedge clk) begin
        stamp_t want;
        if (rst_n && s_tvalid && s_tready)
            expected_stamps.push_back(shifted_stamp(s_tdata));
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_stamps.size() == 0)
                report_mismatch("unexpected result, year", m_tdata[13:0], 0);
            else begin
                want = expected_stamps.pop_front();
                if (m_tdata[13:0] != want.year)
                    report_mismatch("new_year", m_tdata[13:0], want.year);
                if (m_tdata[17:14] != want.month)
                    report_mismatch("new_month", m_tdata[17:14], want.month);
                if (m_tdata[22:18] != want.day)
                    report_mismatch("new_day", m_tdata[22:18], want.day);
                if (m_tdata[27:23] != want.hour)
                    report_mismatch("new_hour", m_tdata[27:23], want.hour);
                if (m_tdata[33:28] != want.minute)
                    report_mismatch("new_minute", m_tdata[33:28], want.minute);
                if (m_tdata[39:34] != want.second)
                    report_mismatch("new_second", m_tdata[39:34], want.second);
                if (m_tdata[40] != want.out_of_range)
                    report_mismatch("out_of_range", m_tdata[40], want.out_of_range);
            end
        end
    end

endmodule

[sim/datetime_add_seconds_tb.sv]
// Testbench top for the date-time add-seconds block: drives date-time requests
// with random gaps and stalls; depends on datetime_add_seconds and its checker.
`timescale 1ns / 1ps

module datetime_add_seconds_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          calm_phase;
    bit          hold_off;

    datetime_add_seconds uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    datetime_add_seconds_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [79:0] pack_request(input logic [13:0] yr, input logic [3:0] mo,
            input logic [4:0] dy, input logic [4:0] hr, input logic [5:0] mi,
            input logic [5:0] se, input logic [33:0] ofs);
        return {6'd0, ofs, se, mi, hr, dy, mo, yr};
    endfunction

    // Hold the request until accepted; random gap before it outside the calm phase
    task automatic send_request(input logic [79:0] req);
        if (!calm_phase)
            while ($urandom_range(99) < 20)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tdata <= req;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [33:0] random_offset();
        case ($urandom_range(5))
            0: return 34'($signed($urandom_range(200000)) - 100000);
            1: return 34'($signed($urandom_range(20000000)) - 10000000);
            2: return 34'({$urandom, $urandom}); // full width
            3: return 34'(86400 * ($signed($urandom_range(800)) - 400));
            default: return 34'($signed($urandom_range(4000000000)) - 2000000000);
        endcase
    endfunction

    always @(negedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [13:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
        int          n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm_phase = 1'b0;
        hold_off = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: extremes, leap rules, odd months/days/times, clamping
        send_request(pack_request(1, 1, 1, 0, 0, 0, 34'h2_0000_0000));
        send_request(pack_request(9999, 12, 31, 23, 59, 59, 34'h1_FFFF_FFFF));
        send_request(pack_request(1, 1, 1, 0, 0, 0, -34'sd1));
        send_request(pack_request(9999, 12, 31, 23, 59, 59, 34'd1));
        send_request(pack_request(2000, 2, 28, 23, 59, 59, 34'd1));
        send_request(pack_request(1900, 2, 28, 23, 59, 59, 34'd1));
        send_request(pack_request(2024, 3, 1, 0, 0, 0, -34'sd1));
        send_request(pack_request(2023, 0, 15, 12, 0, 0, 34'd0));
        send_request(pack_request(2023, 15, 15, 12, 0, 0, 34'd0));
        send_request(pack_request(2023, 4, 0, 0, 0, 0, 34'd0));
        send_request(pack_request(2023, 4, 31, 0, 0, 0, 34'd0));
        send_request(pack_request(2023, 6, 10, 31, 63, 63, 34'd0));
        send_request(pack_request(0, 3, 1, 0, 0, 0, 34'd0));
        send_request(pack_request(0, 2, 29, 0, 0, 0, 34'd86400));
        send_request(pack_request(16383, 15, 31, 31, 63, 63, -34'sd1));
        send_request(pack_request(16383, 1, 1, 0, 0, 0, 34'h2_0000_0000));
        send_request(pack_request(2023, 12, 31, 23, 59, 59, 34'd1));
        send_request(pack_request(2023, 1, 1, 0, 0, 0, -34'sd86400));
        send_request(pack_request(2023, 5, 5, 0, 0, 0, 34'd86399));
        send_request(pack_request(2023, 5, 5, 0, 0, 0, -34'sd86401));
        send_request(pack_request(1, 1, 1, 0, 0, 1, -34'sd1));

        // Receiver stalls for a long stretch while requests keep coming
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (n = 0; n < 40; n++)
            send_request(pack_request(14'($urandom_range(1, 9999)), 4'($urandom_range(1, 12)),
                5'($urandom_range(1, 28)), 5'($urandom_range(23)), 6'($urandom_range(59)),
                6'($urandom_range(59)), random_offset()));

        for (n = 0; n < 1000; n++) begin
            calm_phase = (n >= 400 && n < 550);
            if ($urandom_range(9) == 0) begin
                // raw noise over every bit
                yr = 14'($urandom); mo = 4'($urandom); dy = 5'($urandom);
                hr = 5'($urandom); mi = 6'($urandom); se = 6'($urandom);
            end else begin
                yr = ($urandom_range(3) == 0) ? 14'($urandom_range(1, 9999))
                                             : 14'($urandom_range(1890, 2110));
                mo = 4'($urandom_range(1, 12));
                dy = 5'($urandom_range(1, 31));
                hr = 5'($urandom_range(23));
                mi = 6'($urandom_range(59));
                se = 6'($urandom_range(59));
            end
            send_request(pack_request(yr, mo, dy, hr, mi, se, random_offset()));
        end
        s_tvalid <= 1'b0;
        calm_phase = 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
